### rtl/pfar_pkg.sv
`default_nettype none
package pfar_pkg;

  localparam int MAX_REGIONS  = 64;
  localparam int BITMAP_PAGES = 32768;
  localparam int PAGE_BYTES   = 4096;

  localparam int REG_AW    = $clog2(MAX_REGIONS);
  localparam int CNT_W     = 7;
  localparam int WORD_W    = 64;
  localparam int MAP_WORDS = (BITMAP_PAGES + WORD_W - 1) / WORD_W;
  localparam int MAP_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_AW    = $clog2(WORD_W);
  localparam int PAGE_SH   = $clog2(PAGE_BYTES);
  localparam int PAGE_W    = $clog2(BITMAP_PAGES);
  localparam int ENTRY_W   = 64 + 64 + 1;

  // Commands.
  localparam logic [2:0] CMD_LOAD  = 3'd0;
  localparam logic [2:0] CMD_TO_PH = 3'd1;
  localparam logic [2:0] CMD_TO_PS = 3'd2;
  localparam logic [2:0] CMD_ALLOC = 3'd3;
  localparam logic [2:0] CMD_MARK  = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_NO_FREE = 2'd2;
  localparam logic [1:0] ST_BEYOND  = 2'd3;

  // Result address selection; any other value gives zero.
  localparam logic [1:0] SEL_WALK = 2'd1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [5:0]  region_index;
    logic [63:0] region_base;
    logic [63:0] region_length;
    logic        region_usable;
    logic [63:0] address;
    logic        mark_used;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_address;
    logic [1:0]  status;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;    // latch the input transaction
    logic load_wr;    // write the region entry
    logic walk_start; // clear the walk accumulators
    logic walk_step;  // consume one region entry
    logic ph_mode;    // 1: pseudo to physical walk, 0: physical to pseudo
    logic use_page;   // walk key is the allocated page's pseudo address
    logic scan_start; // start the bitmap scan at word 0
    logic scan_step;  // examine one bitmap word
    logic alloc_set;  // set the found free bit
    logic mark_rd;    // read the bitmap word of the marked page
    logic mark_wr;    // write the marked bit
    logic clr_step;   // clear one bitmap word
    logic set_res;    // load the result register
    logic [1:0] res_sel; // SEL_WALK: walk result, otherwise zero
    logic [1:0] res_st;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] cmd;
    logic walk_last;   // the current entry is the last live one
    logic walk_hit;    // the current entry matches
    logic walk_none;   // no live entries at all
    logic scan_found;  // current word has a free bit
    logic scan_last;   // current word is the last
    logic mark_beyond; // marked page lies beyond the bitmap
    logic clr_last;    // clearing pass reached the last word
  } sts_t;

endpackage
`default_nettype wire

### rtl/pfar_ram.sv
`default_nettype none
module pfar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/pfar_datapath.sv
`default_nettype none
module pfar_datapath
  import pfar_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire in_item_t   in_item,
  input  wire logic [CNT_W-1:0] region_count,
  input  wire ctl_t       ctl,
  output sts_t            sts,
  output out_item_t       res
);

  in_item_t item;
  logic [REG_AW-1:0] walk_idx;
  logic [63:0] rest;
  logic [63:0] prior;
  logic [63:0] key;
  logic [MAP_AW-1:0] word_idx;
  logic [BIT_AW-1:0] free_bit;
  logic [PAGE_W-1:0] page;
  logic [CNT_W-1:0] live;

  logic [ENTRY_W-1:0] ent_rd;
  logic [63:0] ent_start, ent_size;
  logic ent_use;
  logic [WORD_W-1:0] word_rd;
  logic map_we;
  logic [MAP_AW-1:0] map_waddr, map_raddr;
  logic [WORD_W-1:0] map_wdata;
  logic [REG_AW-1:0] ent_raddr;
  logic [63:0] off;
  logic hit_ph, hit_ps;
  logic [BIT_AW-1:0] first_free;
  logic any_free;
  logic [63:0] ps_addr;
  logic [63:0] walk_key;
  logic [WORD_W-1:0] word_hold;

  assign live = (region_count > CNT_W'(MAX_REGIONS)) ? CNT_W'(MAX_REGIONS) : region_count;

  // Region table: start, size and usable flag in one entry.
  assign ent_raddr = ctl.walk_start ? '0 : walk_idx + REG_AW'(ctl.walk_step);
  pfar_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_REGIONS)) u_regions (
    .clk   (clk),
    .we    (ctl.load_wr),
    .waddr (item.region_index[REG_AW-1:0]),
    .wdata ({item.region_base, item.region_length, item.region_usable}),
    .raddr (ent_raddr),
    .rdata (ent_rd)
  );
  assign {ent_start, ent_size, ent_use} = ent_rd;

  // Page bitmap, one 64-bit word per address.
  pfar_ram #(.WIDTH(WORD_W), .DEPTH(MAP_WORDS)) u_bitmap (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (word_rd)
  );

  // Lowest clear bit of the word that was read.
  always_comb begin
    first_free = '0;
    any_free   = 1'b0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!word_rd[b]) begin
        first_free = BIT_AW'(b);
        any_free   = 1'b1;
      end
    end
  end

  assign ps_addr  = {{(64-PAGE_W-PAGE_SH){1'b0}}, page, {PAGE_SH{1'b0}}};
  assign walk_key = ctl.use_page ? ps_addr : item.address;

  // Bitmap address and write selection.
  always_comb begin
    map_raddr = ctl.scan_start ? '0 : word_idx + MAP_AW'(ctl.scan_step);
    if (ctl.mark_rd) begin
      map_raddr = prior[PAGE_SH+BIT_AW +: MAP_AW];
    end
    map_we    = ctl.clr_step | ctl.alloc_set | ctl.mark_wr;
    map_waddr = word_idx;
    map_wdata = '0;
    if (ctl.alloc_set) begin
      map_wdata = word_hold | (WORD_W'(1) << free_bit);
    end else if (ctl.mark_wr) begin
      map_wdata = item.mark_used ? (word_rd | (WORD_W'(1) << prior[PAGE_SH +: BIT_AW]))
                                 : (word_rd & ~(WORD_W'(1) << prior[PAGE_SH +: BIT_AW]));
    end
  end

  // Walk compare on the current entry.
  assign off    = key - ent_start;
  assign hit_ph = ent_use && (ent_size > rest);
  assign hit_ps = ent_use && (key >= ent_start) && (off < ent_size);

  assign sts.cmd         = item.cmd;
  assign sts.walk_last   = (walk_idx == REG_AW'(live - 1'b1));
  assign sts.walk_hit    = ctl.ph_mode ? hit_ph : hit_ps;
  assign sts.walk_none   = (live == '0);
  assign sts.scan_found  = any_free;
  assign sts.scan_last   = (word_idx == MAP_AW'(MAP_WORDS - 1));
  assign sts.mark_beyond = (prior >> (PAGE_SH + PAGE_W)) != '0;
  assign sts.clr_last    = (word_idx == MAP_AW'(MAP_WORDS - 1));

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item <= in_item;
    end
    if (ctl.walk_start) begin
      walk_idx <= '0;
      prior    <= '0;
      rest     <= walk_key;
      key      <= walk_key;
    end else if (ctl.walk_step) begin
      if (sts.walk_hit) begin
        // Hold the answer: physical in rest, pseudo in prior.
        rest  <= ctl.ph_mode ? ent_start + rest : off + prior;
        prior <= off + prior;
      end else begin
        walk_idx <= walk_idx + 1'b1;
        if (ent_use) begin
          rest  <= rest - ent_size;
          prior <= prior + ent_size;
        end
      end
    end
    if (rst) begin
      word_idx <= '0;
    end else if (ctl.scan_start) begin
      word_idx <= '0;
    end else if (ctl.mark_rd) begin
      word_idx <= prior[PAGE_SH+BIT_AW +: MAP_AW];
    end else if (ctl.scan_step && !any_free) begin
      word_idx <= word_idx + 1'b1;
    end else if (ctl.scan_step) begin
      free_bit  <= first_free;
      word_hold <= word_rd;
      page      <= PAGE_W'({word_idx, first_free});
    end else if (ctl.clr_step) begin
      word_idx <= word_idx + 1'b1;
    end
    if (ctl.set_res) begin
      res.status <= ctl.res_st;
      case (ctl.res_sel)
        SEL_WALK: res.result_address <= ctl.ph_mode ? rest : prior;
        default:  res.result_address <= '0;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/pfar_controller.sv
`default_nettype none
module pfar_controller
  import pfar_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output ctl_t      ctl
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_WALK  = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_SET   = 4'd5;
  localparam logic [3:0] S_AWALK = 4'd6;
  localparam logic [3:0] S_MRD   = 4'd7;
  localparam logic [3:0] S_MWR   = 4'd8;
  localparam logic [3:0] S_WPRE  = 4'd9;
  localparam logic [3:0] S_SPRE  = 4'd10;

  logic [3:0] state, state_next;
  logic out_valid_next;
  logic take;

  assign take     = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  always_comb begin
    ctl            = '0;
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    ctl.ph_mode    = (sts.cmd != CMD_TO_PS) && (sts.cmd != CMD_MARK);
    case (state)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ctl.capture = take;
        if (take) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.cmd)
          CMD_LOAD: begin
            ctl.load_wr = 1'b1;
            ctl.set_res = 1'b1;
            out_valid_next = 1'b1;
            state_next = S_IDLE;
          end
          CMD_TO_PH, CMD_TO_PS, CMD_MARK: begin
            ctl.walk_start = 1'b1;
            state_next = S_WPRE;
          end
          CMD_ALLOC: begin
            ctl.scan_start = 1'b1;
            state_next = S_SPRE;
          end
          default: begin
            ctl.set_res = 1'b1;
            out_valid_next = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_WPRE, S_AWALK: begin
        // Region entry 0 is being read; no compare yet.
        if (sts.walk_none) begin
          ctl.set_res = 1'b1;
          ctl.res_st  = ST_OUTSIDE;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        ctl.walk_step = 1'b1;
        if (sts.walk_hit) begin
          if (sts.cmd == CMD_MARK) begin
            state_next = S_MRD;
          end else begin
            ctl.set_res = 1'b0;
            state_next = S_MWR;
          end
        end else if (sts.walk_last) begin
          ctl.set_res = 1'b1;
          ctl.res_st  = ST_OUTSIDE;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MRD: begin
        // Page index check, then read the bitmap word.
        if (sts.mark_beyond) begin
          ctl.set_res = 1'b1;
          ctl.res_st  = ST_BEYOND;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.mark_rd = 1'b1;
          state_next = S_SET;
        end
      end
      S_SET: begin
        if (sts.cmd == CMD_MARK) begin
          ctl.mark_wr = 1'b1;
          state_next = S_MWR;
        end else begin
          ctl.alloc_set = 1'b1;
          ctl.walk_start = 1'b1;
          ctl.use_page = 1'b1;
          state_next = S_AWALK;
        end
      end
      S_MWR: begin
        // Result from the held walk answer.
        ctl.set_res = 1'b1;
        ctl.res_sel = SEL_WALK;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      S_SPRE: begin
        ctl.scan_step = 1'b0;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_found) begin
          state_next = S_SET;
        end else if (sts.scan_last) begin
          ctl.set_res = 1'b1;
          ctl.res_st  = ST_NO_FREE;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_SPRE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

### rtl/page_frame_allocator_remap_unit.sv
`default_nettype none
// Page frame allocator with a region table remap. One transaction is taken at a time
// and gives one result. After reset a clearing pass (one bitmap word a cycle, over
// all 512 words) runs before the first transaction is taken. A load writes its region
// entry at dispatch; a translation walks the live region entries in order up to the
// hit, or through all of them on a miss; a mark that writes its page then reads and
// writes its bitmap word; an allocation scans the bitmap one 64-page word at a time
// for the lowest free page, sets it, then walks the table for its translation. The
// next transaction is taken at the edge where the result leaves. The region table
// and the bitmap have registered reads.
module page_frame_allocator_remap_unit
  import pfar_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_data
);

  ctl_t ctl;
  sts_t sts;
  logic [CNT_W-1:0] region_count;

  // Region count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= '0;
    end else if (cfg_we) begin
      region_count <= cfg_data;
    end
  end

  pfar_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  pfar_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_item      (in_data),
    .region_count (region_count),
    .ctl          (ctl),
    .sts          (sts),
    .res          (out_data)
  );

endmodule
`default_nettype wire

### rtl/pfar_checker.sv
`default_nettype none
module pfar_checker
  import pfar_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // No new transaction is taken while a result waits.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result pending");

  // A result is never shown in the cycle after acceptance.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("result too early");

  // A failed lookup never reports an address.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.result_address == '0)
    else $error("error result carries an address");

endmodule

bind page_frame_allocator_remap_unit pfar_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

### verif/tb_page_frame_allocator_remap_unit.sv
`timescale 1ns / 1ps
module tb_page_frame_allocator_remap_unit;
  import pfar_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;

  page_frame_allocator_remap_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow copy of the block's state, used to predict each result.
  logic [63:0] shadow_start [MAX_REGIONS];
  logic [63:0] shadow_size [MAX_REGIONS];
  logic shadow_usable [MAX_REGIONS];
  logic shadow_loaded [MAX_REGIONS];
  logic shadow_map [BITMAP_PAGES];
  logic [CNT_W-1:0] shadow_count;

  in_item_t pending_items[$];
  out_item_t awaited_results[$];
  int error_count = 0;
  int accepted_count = 0;
  int result_count = 0;
  int alloc_count = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic int live_regions();
    return (shadow_count > MAX_REGIONS) ? MAX_REGIONS : int'(shadow_count);
  endfunction

  function automatic bit walk_to_physical(input logic [63:0] pseudo, output logic [63:0] phys);
    logic [63:0] rest;
    rest = pseudo;
    phys = '0;
    for (int k = 0; k < live_regions(); k++) begin
      if (!shadow_usable[k]) continue;
      if (shadow_size[k] > rest) begin
        phys = shadow_start[k] + rest;
        return 1'b1;
      end
      rest -= shadow_size[k];
    end
    return 1'b0;
  endfunction

  function automatic bit walk_to_pseudo(input logic [63:0] phys, output logic [63:0] pseudo);
    logic [63:0] sum_before;
    sum_before = '0;
    pseudo = '0;
    for (int k = 0; k < live_regions(); k++) begin
      if (!shadow_usable[k]) continue;
      if (phys >= shadow_start[k] && phys - shadow_start[k] < shadow_size[k]) begin
        pseudo = sum_before + (phys - shadow_start[k]);
        return 1'b1;
      end
      sum_before += shadow_size[k];
    end
    return 1'b0;
  endfunction

  // Works out the result of one transaction and updates the shadow state.
  function automatic out_item_t predict_allocator(input in_item_t it);
    out_item_t r;
    logic [63:0] t;
    int page;
    r.result_address = '0;
    r.status = ST_OK;
    case (it.cmd)
      CMD_LOAD: begin
        shadow_start[it.region_index] = it.region_base;
        shadow_size[it.region_index] = it.region_length;
        shadow_usable[it.region_index] = it.region_usable;
        shadow_loaded[it.region_index] = 1'b1;
      end
      CMD_TO_PH: begin
        if (walk_to_physical(it.address, t)) r.result_address = t;
        else r.status = ST_OUTSIDE;
      end
      CMD_TO_PS: begin
        if (walk_to_pseudo(it.address, t)) r.result_address = t;
        else r.status = ST_OUTSIDE;
      end
      CMD_ALLOC: begin
        page = -1;
        for (int p = 0; p < BITMAP_PAGES; p++) begin
          if (!shadow_map[p]) begin
            page = p;
            break;
          end
        end
        if (page < 0) begin
          r.status = ST_NO_FREE;
        end else begin
          shadow_map[page] = 1'b1;
          if (walk_to_physical(64'(page) * PAGE_BYTES, t)) r.result_address = t;
          else r.status = ST_OUTSIDE;
        end
      end
      CMD_MARK: begin
        if (!walk_to_pseudo(it.address, t)) begin
          r.status = ST_OUTSIDE;
        end else if (t / PAGE_BYTES >= BITMAP_PAGES) begin
          r.status = ST_BEYOND;
        end else begin
          shadow_map[t / PAGE_BYTES] = it.mark_used;
          r.result_address = t;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: bursts of transactions separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  bit hold_off = 1'b0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        awaited_results.push_back(predict_allocator(in_data));
        accepted_count++;
      end
      if (in_valid && in_stall) begin
        // The stalled transaction stays as it is.
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() > 0 && !hold_off) begin
        in_valid <= 1'b1;
        in_data <= pending_items.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: quiet and busy phases of random length.
  int stall_phase = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_phase <= $urandom_range(10, 200);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // Monitor: compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      result_count++;
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        exp_r = awaited_results.pop_front();
        if (out_data.result_address !== exp_r.result_address)
          report_mismatch($sformatf("address got %h want %h",
                                    out_data.result_address, exp_r.result_address));
        if (out_data.status !== exp_r.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_data.status, exp_r.status));
      end
    end
  end

  function automatic in_item_t blank_item(input logic [2:0] c);
    in_item_t it;
    it.cmd = c;
    it.region_index = 6'($urandom);
    it.region_base = {$urandom, $urandom};
    it.region_length = {$urandom, $urandom};
    it.region_usable = 1'($urandom);
    it.address = {$urandom, $urandom};
    it.mark_used = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t load_item(input int slot, input logic [63:0] base,
                                         input logic [63:0] len, input logic usable);
    in_item_t it;
    it = blank_item(CMD_LOAD);
    it.region_index = 6'(slot);
    it.region_base = base;
    it.region_length = len;
    it.region_usable = usable;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Physical address near a loaded region, often inside it.
  function automatic logic [63:0] near_physical(input int n);
    int k;
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 4))
      0: return rand64();
      1: return shadow_start[k] + shadow_size[k] - 1;
      2: return shadow_start[k] + shadow_size[k];
      default: return shadow_start[k] + (shadow_size[k] == 0 ? 0 :
                      rand64() % shadow_size[k]);
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || awaited_results.size() > 0)
      @(posedge clk);
    hold_off = 1'b1;
    repeat (40) @(posedge clk);
  endtask

  task automatic write_count(input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= CNT_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_count = CNT_W'(value);
    @(posedge clk);
    hold_off = 1'b0;
  endtask

  // Queues loads of n slots and returns; the table then stays defined for those slots.
  task automatic queue_table(input int n, input bit tiny);
    logic [63:0] base;
    logic [63:0] len;
    for (int k = 0; k < n; k++) begin
      base = tiny ? 64'({$urandom_range(0, 1 << 20)} << 12) : rand64();
      len = tiny ? 64'($urandom_range(0, 64) * PAGE_BYTES + $urandom_range(0, 1) * 100)
                 : rand64() >> $urandom_range(0, 63);
      pending_items.push_back(load_item(k, base, len, $urandom_range(0, 3) != 0));
      shadow_start[k] = base;
      shadow_size[k] = len;
    end
  endtask

  // Shadow values written by queue_table are overwritten by predict at acceptance; they only
  // steer address choice for the stimulus.
  task automatic queue_random(input int count, input int n);
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0, 1: it = blank_item(3'($urandom_range(5, 7)));
        2, 3, 4, 5: begin
          it = blank_item(CMD_TO_PH);
          if ($urandom_range(0, 2) != 0) it.address = rand64() % (64'(n) * 64'h40000 + 1);
        end
        6, 7, 8, 9, 10: begin
          it = blank_item(CMD_TO_PS);
          if (n > 0) it.address = near_physical(n);
        end
        11: it = blank_item(CMD_ALLOC);
        default: begin
          it = blank_item(CMD_MARK);
          if (n > 0) it.address = near_physical(n);
        end
      endcase
      pending_items.push_back(it);
    end
  endtask

  initial begin
    in_item_t it;
    int n;
    for (int p = 0; p < BITMAP_PAGES; p++) shadow_map[p] = 1'b0;
    for (int k = 0; k < MAX_REGIONS; k++) begin
      shadow_loaded[k] = 1'b0;
      shadow_usable[k] = 1'b0;
      shadow_size[k] = '0;
      shadow_start[k] = '0;
    end
    shadow_count = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: with no regions every lookup misses, loads ignore the count.
    hold_off = 1'b0;
    pending_items.push_back(blank_item(CMD_TO_PH));
    pending_items.push_back(blank_item(CMD_TO_PS));
    pending_items.push_back(blank_item(CMD_ALLOC));
    pending_items.push_back(blank_item(CMD_MARK));
    pending_items.push_back(blank_item(3'd7));
    pending_items.push_back(load_item(0, 64'h0, 64'h2000, 1'b1));
    pending_items.push_back(load_item(1, 64'h10_0000, 64'h5000, 1'b0));
    pending_items.push_back(load_item(2, 64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
    pending_items.push_back(load_item(63, 64'h0, 64'h0, 1'b1));
    wait_idle();
    write_count(3);
    it = blank_item(CMD_TO_PH); it.address = 64'h0; pending_items.push_back(it);
    it = blank_item(CMD_TO_PH); it.address = 64'h1FFF; pending_items.push_back(it);
    it = blank_item(CMD_TO_PH); it.address = 64'h2000; pending_items.push_back(it);
    it = blank_item(CMD_TO_PH); it.address = '1; pending_items.push_back(it);
    it = blank_item(CMD_TO_PS); it.address = 64'h10_0000; pending_items.push_back(it);
    it = blank_item(CMD_TO_PS); it.address = '1; pending_items.push_back(it);
    it = blank_item(CMD_TO_PS); it.address = 64'hFFFF_FFFF_FFFF_F000; pending_items.push_back(it);
    it = blank_item(CMD_MARK); it.address = 64'h1000; it.mark_used = 1'b1;
    pending_items.push_back(it);
    pending_items.push_back(blank_item(CMD_ALLOC));
    pending_items.push_back(blank_item(CMD_ALLOC));
    it = blank_item(CMD_MARK); it.address = 64'h1000; it.mark_used = 1'b0;
    pending_items.push_back(it);
    // Last byte of the address space, inside the top region.
    it = blank_item(CMD_MARK); it.address = '1; pending_items.push_back(it);
    wait_idle();

    // Random phases over several table sizes, count settings at the extremes.
    for (int phase = 0; phase < 8; phase++) begin
      n = (phase == 0) ? 1 : (phase == 1) ? MAX_REGIONS : $urandom_range(1, MAX_REGIONS);
      hold_off = 1'b0;
      queue_table(n, phase % 2 == 0);
      wait_idle();
      // Counts above the table limit act as the limit, so 127 is safe once full.
      write_count((n == MAX_REGIONS && phase == 1) ? 127 : n);
      queue_random(120, n);
      wait_idle();
    end

    // Mark a run of low pages used so that allocation has to skip past them.
    hold_off = 1'b0;
    pending_items.push_back(load_item(0, 64'h4000_0000, 64'(BITMAP_PAGES) * PAGE_BYTES, 1'b1));
    wait_idle();
    write_count(1);
    for (int p = 0; p < 128; p++) begin
      it = blank_item(CMD_MARK);
      it.address = 64'h4000_0000 + 64'(p) * PAGE_BYTES;
      it.mark_used = 1'b1;
      pending_items.push_back(it);
      if (p % 32 == 0) pending_items.push_back(blank_item(CMD_ALLOC));
    end
    wait_idle();
    hold_off = 1'b0;
    for (int i = 0; i < 20; i++) pending_items.push_back(blank_item(CMD_ALLOC));
    wait_idle();
    write_count(0);
    pending_items.push_back(blank_item(CMD_ALLOC));
    wait_idle();

    $display("Covered %0d transactions and %0d results over several table sizes,",
             accepted_count, result_count);
    $display("including translation misses, pages past the bitmap end and used page runs.");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #800ms;
    $display("simulation failed");
    $finish;
  end

endmodule
